// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the key-value table.
// Each macro expands to one labeled concurrent assertion on a rising clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KVT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key_value_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key_value_table: next-cycle check failed");

`endif

// ===== rtl/kvt_pkg.sv =====
// Package of the key-value table: field widths, operation and status codes,
// and the control struct that the top level hands to each storage cell.
`default_nettype none

package kvt_pkg;

  // Default sizes of the table.
  localparam int KVT_CAPACITY    = 8;
  localparam int KVT_KEY_WIDTH   = 32;
  localparam int KVT_VALUE_WIDTH = 32;

  // Fixed widths of the item fields.
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int RDVAL_W   = 32;
  localparam int POS_W     = 3;
  localparam int CNT_OUT_W = 4;

  // Operation codes; the unused code behaves as a lookup.
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

  // Per-cell write controls: load a fresh pair, overwrite the value,
  // or take the pair held by the next cell up the chain.
  typedef struct packed {
    logic ins;
    logic upd;
    logic shift;
  } kvt_cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/kvt_cell.sv =====
// One storage cell of the key-value table: a key and value register pair
// with its own key comparator. Depends on kvt_pkg for the control struct.
`default_nettype none

module kvt_cell #(
  parameter int KEY_WIDTH   = kvt_pkg::KVT_KEY_WIDTH,
  parameter int VALUE_WIDTH = kvt_pkg::KVT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  kvt_pkg::kvt_cell_ctl_t ctl,
  input  logic                   active,
  input  logic [KEY_WIDTH-1:0]   req_key,
  input  logic [VALUE_WIDTH-1:0] req_value,
  input  logic [KEY_WIDTH-1:0]   nb_key,
  input  logic [VALUE_WIDTH-1:0] nb_value,
  output logic [KEY_WIDTH-1:0]   key_o,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   hit
);
  import kvt_pkg::*;

  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;

  // The pair is loaded, updated in place, or shifted down from the neighbor.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      key_r   <= req_key;
      value_r <= req_value;
    end else if (ctl.upd) begin
      value_r <= req_value;
    end else if (ctl.shift) begin
      key_r   <= nb_key;
      value_r <= nb_value;
    end
  end

  // Only cells below the entry count take part in the match.
  assign hit     = active && (key_r == req_key);
  assign key_o   = key_r;
  assign value_o = value_r;

endmodule

`default_nettype wire

// ===== rtl/key_value_table.sv =====
// Top level of the key-value table: the chain of storage cells, the entry
// count, the result logic and the output register. Depends on kvt_pkg and kvt_cell.

// The table answers one item per clock cycle when it is not stalled. Every
// stored key is compared against the request in the same cycle by its own
// cell, so an insert, a remove with its shift toward the head, or a lookup
// completes at the edge that accepts the item, and its result sits in the
// output register from the next cycle on. A new item is taken while a result
// waits only if that result is taken in the same cycle; in_stall follows
// out_stall while a result is held. The table needs no clearing after reset:
// the entry count starts at zero and cells at or above the count never answer.
`default_nettype none

module key_value_table #(
  parameter int CAPACITY    = kvt_pkg::KVT_CAPACITY,
  parameter int KEY_WIDTH   = kvt_pkg::KVT_KEY_WIDTH,
  parameter int VALUE_WIDTH = kvt_pkg::KVT_VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kvt_pkg::FUNC_W-1:0]     in_func,
  input  logic [KEY_WIDTH-1:0]           in_key,
  input  logic [VALUE_WIDTH-1:0]         in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kvt_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_found,
  output logic [kvt_pkg::RDVAL_W-1:0]    out_read_value,
  output logic [kvt_pkg::POS_W-1:0]      out_position,
  output logic [kvt_pkg::CNT_OUT_W-1:0]  out_entry_count,
  output logic                           out_empty_res
);
  import kvt_pkg::*;

`include "assert_macros.svh"

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);

  logic                   accept;
  logic                   op_insert;
  logic                   op_remove;
  logic                   full;
  logic                   any_hit;
  logic [IdxW-1:0]        hit_pos;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [CAPACITY-1:0]    hit_vec;
  logic [KEY_WIDTH-1:0]   key_q   [CAPACITY];
  logic [VALUE_WIDTH-1:0] value_q [CAPACITY];

  logic [CntW-1:0]        count_r, count_nxt;
  logic                   out_valid_r;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic                   found_r;
  logic [RDVAL_W-1:0]     read_value_r, read_value_nxt;
  logic [POS_W-1:0]       position_r;
  logic [CNT_OUT_W-1:0]   entry_count_r;
  logic                   empty_r;

  // Handshake: a held result blocks the input only while it is stalled.
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign op_insert = (in_func == FN_INSERT);
  assign op_remove = (in_func == FN_REMOVE);
  assign full      = (count_r == CntW'(CAPACITY));

  // Chain of cells; each one may take the pair of its upper neighbor.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    localparam logic [CntW-1:0] CellIdx = CntW'(gi);
    localparam logic [IdxW-1:0] CellPos = IdxW'(gi);

    kvt_cell_ctl_t          cell_ctl;
    logic [KEY_WIDTH-1:0]   nb_key;
    logic [VALUE_WIDTH-1:0] nb_value;

    if (gi < CAPACITY - 1) begin : g_nb
      assign nb_key   = key_q[gi+1];
      assign nb_value = value_q[gi+1];
    end else begin : g_last
      assign nb_key   = '0;
      assign nb_value = '0;
    end

    assign cell_ctl.ins   = accept && op_insert && !any_hit && !full && (count_r == CellIdx);
    assign cell_ctl.upd   = accept && op_insert && any_hit && (hit_pos == CellPos);
    assign cell_ctl.shift = accept && op_remove && any_hit && (CellPos >= hit_pos);

    kvt_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .active   (CellIdx < count_r),
      .req_key  (in_key),
      .req_value(in_value),
      .nb_key   (nb_key),
      .nb_value (nb_value),
      .key_o    (key_q[gi]),
      .value_o  (value_q[gi]),
      .hit      (hit_vec[gi])
    );
  end

  // Lowest matching cell gives the position and the stored value.
  always_comb begin
    any_hit   = |hit_vec;
    hit_pos   = '0;
    hit_value = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_pos   = IdxW'(i);
        hit_value = value_q[i];
      end
    end
  end

  // Status, read value and new entry count for the request.
  always_comb begin
    count_nxt      = count_r;
    read_value_nxt = '0;
    status_nxt     = ST_MISS;
    case (in_func)
      FN_INSERT: begin
        if (any_hit) begin
          status_nxt = ST_UPDATED;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          count_nxt  = count_r + CntW'(1);
        end
      end
      FN_REMOVE: begin
        if (any_hit) begin
          status_nxt = ST_REMOVED;
          count_nxt  = count_r - CntW'(1);
        end
      end
      default: begin
        if (any_hit) begin
          status_nxt     = ST_HIT;
          read_value_nxt = RDVAL_W'(hit_value);
        end
      end
    endcase
  end

  // Control state: entry count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      out_valid_r <= accept | (out_valid_r & out_stall);
    end
  end

  // Result register, loaded when an item is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      found_r       <= any_hit;
      read_value_r  <= read_value_nxt;
      position_r    <= POS_W'(hit_pos);
      entry_count_r <= CNT_OUT_W'(count_nxt);
      empty_r       <= (count_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found       = found_r;
  assign out_read_value  = read_value_r;
  assign out_position    = position_r;
  assign out_entry_count = entry_count_r;
  assign out_empty_res   = empty_r;

  // Checks on the table's own bookkeeping.
  `KVT_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CntW'(CAPACITY))
  `KVT_ASSERT_IMPL(a_unique_hit, clk, rst_n, 1'b1, $onehot0(hit_vec))
  `KVT_ASSERT_NEXT(a_remove_count, clk, rst_n, accept && op_remove && any_hit, count_r == $past(count_r) - CntW'(1))
  `KVT_ASSERT_IMPL(a_full_held, clk, rst_n, out_valid_r && (status_r == ST_FULL), full)

endmodule

`default_nettype wire
